// ===== hw/rtl/huffman_tree_code_builder_macros.svh =====
// Assertion helpers used by the bound checker in htcb_checker.sv.
`ifndef HUFFMAN_TREE_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_TREE_CODE_BUILDER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HTCB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("htcb: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define HTCB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("htcb: next-cycle check failed");

`endif

// ===== hw/rtl/htcb_pkg.sv =====
package htcb_pkg;

	// Capacity and weight width
	localparam int MAX_SYMBOLS = 16;
	localparam int WEIGHT_BITS = 16;

	// Tree storage
	localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1);
	localparam int NODE_W     = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
	localparam int LEN_W      = $clog2(MAX_SYMBOLS);

	// Fixed port field widths
	localparam int IN_W   = 16;
	localparam int SYM_W  = 4;
	localparam int CODE_W = 15;
	localparam int CLEN_W = 4;

	localparam logic [NODE_W-1:0] WMASK = {NODE_W{1'b1}} >> (NODE_W - WEIGHT_BITS);

	// Commands from controller to datapath
	typedef struct packed {
		logic accept_en;
		logic build_init;
		logic scan_issue;
		logic merge_a;
		logic merge_b;
		logic walk_init;
		logic walk_fetch;
		logic walk_step;
		logic emit;
	} htcb_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic in_last_fire;
		logic single;
		logic scan_last;
		logic merge_done;
		logic has_parent;
		logic out_free;
		logic last_leaf;
	} htcb_sts_t;

endpackage

// ===== hw/rtl/htcb_in_if.sv =====
interface htcb_in_if;
	import htcb_pkg::*;

	logic              valid;
	logic              ready;
	logic [IN_W-1:0]   weight;
	logic              last_weight;

	modport source (output valid, output weight, output last_weight, input ready);
	modport sink   (input valid, input weight, input last_weight, output ready);
endinterface

// ===== hw/rtl/htcb_out_if.sv =====
interface htcb_out_if;
	import htcb_pkg::*;

	logic              valid;
	logic              ready;
	logic [SYM_W-1:0]  symbol;
	logic [CODE_W-1:0] code_bits;
	logic [CLEN_W-1:0] code_length;
	logic              last_code;

	modport source (output valid, output symbol, output code_bits, output code_length,
		output last_code, input ready);
	modport sink   (input valid, input symbol, input code_bits, input code_length,
		input last_code, output ready);
endinterface

// ===== hw/rtl/htcb_datapath.sv =====
module htcb_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  htcb_pkg::htcb_cmd_t cmd,
	output htcb_pkg::htcb_sts_t sts,
	htcb_in_if.sink            weights,
	htcb_out_if.source         codes
);
	import htcb_pkg::*;

	// Node stores
	logic [NODE_W-1:0] weight_mem [NODE_COUNT];
	logic [IDX_W-1:0]  parent_mem [NODE_COUNT];
	logic [IDX_W-1:0]  left_mem   [NODE_COUNT];
	logic [NODE_COUNT-1:0] has_parent_q;

	logic [CNT_W-1:0]  cnt_q, k_q;
	logic [IDX_W-1:0]  i_q, j_q, j_s1, b1_q, b2_q, c_q, p_q, prd_q, lrd_q, pr_addr;
	logic              v_s1, hp_s1, f1_q, f2_q, hp_q;
	logic [NODE_W-1:0] w1_q, w2_q, wrd_s1;
	logic [LEN_W-1:0]  len_q;
	logic [CODE_W-1:0] code_q, code_nxt;
	logic              out_valid_q, last_q;
	logic [SYM_W-1:0]  sym_q;
	logic [CODE_W-1:0] codeo_q;
	logic [CLEN_W-1:0] clen_q;
	logic              load_fire, full, cand;
	logic [IDX_W:0]    m_ext;

	assign load_fire = cmd.accept_en && weights.valid;
	assign full      = (cnt_q == CNT_W'(MAX_SYMBOLS));
	assign cand      = v_s1 && !hp_s1;
	assign m_ext     = ((IDX_W+1)'(cnt_q) << 1) - (IDX_W+1)'(1);
	assign pr_addr   = cmd.walk_init ? IDX_W'(k_q) : prd_q;

	// Status back to the controller
	assign sts.in_last_fire = load_fire && weights.last_weight;
	assign sts.single       = (cnt_q == CNT_W'(1));
	assign sts.scan_last    = ((IDX_W+1)'(j_q) + (IDX_W+1)'(1)) == (IDX_W+1)'(i_q);
	assign sts.merge_done   = ((IDX_W+1)'(i_q) + (IDX_W+1)'(1)) == m_ext;
	assign sts.has_parent   = hp_q;
	assign sts.out_free     = !out_valid_q || codes.ready;
	assign sts.last_leaf    = ((CNT_W+1)'(k_q) + (CNT_W+1)'(1)) == (CNT_W+1)'(cnt_q);

	assign weights.ready     = cmd.accept_en;
	assign codes.valid       = out_valid_q;
	assign codes.symbol      = sym_q;
	assign codes.code_bits   = codeo_q;
	assign codes.code_length = clen_q;
	assign codes.last_code   = last_q;

	// Set the branch bit when the child is the right one
	always_comb begin
		code_nxt = code_q;
		if (lrd_q != c_q && int'(len_q) < CODE_W) begin
			code_nxt = code_q | (CODE_W'(1) << len_q);
		end
	end

	// Weight store: loads and merged sums in, scan reads out
	always_ff @(posedge clk) begin
		if (load_fire && !full) begin
			weight_mem[IDX_W'(cnt_q)] <= WMASK & NODE_W'(weights.weight);
		end else if (cmd.merge_a) begin
			weight_mem[i_q] <= w1_q + w2_q;
		end
		wrd_s1 <= weight_mem[j_q];
	end

	// Parent and left-child stores, read along the walk
	always_ff @(posedge clk) begin
		if (cmd.merge_a) begin
			parent_mem[b1_q] <= i_q;
			left_mem[i_q]    <= b2_q;
		end else if (cmd.merge_b) begin
			parent_mem[b2_q] <= i_q;
		end
		prd_q <= parent_mem[pr_addr];
		lrd_q <= left_mem[prd_q];
	end

	// Control counters, flags and the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			k_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			v_s1         <= 1'b0;
			f1_q         <= 1'b0;
			f2_q         <= 1'b0;
			hp_q         <= 1'b0;
			has_parent_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_issue;
			if (load_fire && !full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.build_init) begin
				i_q          <= IDX_W'(cnt_q);
				k_q          <= '0;
				has_parent_q <= '0;
			end
			if (cmd.build_init || cmd.merge_b) begin
				j_q  <= '0;
				f1_q <= 1'b0;
				f2_q <= 1'b0;
			end
			if (cmd.merge_b) begin
				i_q <= i_q + IDX_W'(1);
			end
			if (cmd.scan_issue) begin
				j_q <= j_q + IDX_W'(1);
			end
			// Track the two lightest free nodes, earlier index wins ties
			if (cand) begin
				if (!f1_q || wrd_s1 < w1_q) begin
					f2_q <= f1_q;
					f1_q <= 1'b1;
				end else if (!f2_q || wrd_s1 < w2_q) begin
					f2_q <= 1'b1;
				end
			end
			if (cmd.merge_a) begin
				has_parent_q[b1_q] <= 1'b1;
				has_parent_q[b2_q] <= 1'b1;
			end
			if (cmd.walk_init) begin
				hp_q <= has_parent_q[IDX_W'(k_q)];
			end else if ((cmd.walk_fetch || cmd.walk_step) && hp_q) begin
				hp_q <= has_parent_q[prd_q];
			end
			if (cmd.emit) begin
				k_q <= k_q + CNT_W'(1);
				if (sts.last_leaf) begin
					cnt_q <= '0;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (codes.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		j_s1  <= j_q;
		hp_s1 <= has_parent_q[j_q];
		if (cand) begin
			if (!f1_q || wrd_s1 < w1_q) begin
				b2_q <= b1_q;
				w2_q <= w1_q;
				b1_q <= j_s1;
				w1_q <= wrd_s1;
			end else if (!f2_q || wrd_s1 < w2_q) begin
				b2_q <= j_s1;
				w2_q <= wrd_s1;
			end
		end
		if (cmd.walk_init) begin
			c_q    <= IDX_W'(k_q);
			code_q <= '0;
			len_q  <= '0;
		end else if (cmd.walk_fetch && hp_q) begin
			p_q <= prd_q;
		end else if (cmd.walk_step) begin
			code_q <= code_nxt;
			len_q  <= len_q + LEN_W'(1);
			c_q    <= p_q;
			if (hp_q) begin
				p_q <= prd_q;
			end
		end
		if (cmd.emit) begin
			sym_q   <= SYM_W'(k_q);
			codeo_q <= code_q;
			clen_q  <= CLEN_W'(len_q);
			last_q  <= sts.last_leaf;
		end
	end

endmodule

// ===== hw/rtl/htcb_ctrl.sv =====
module htcb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  htcb_pkg::htcb_sts_t sts,
	output htcb_pkg::htcb_cmd_t cmd
);
	import htcb_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_SCAN,
		ST_DRAIN,
		ST_MERGE_A,
		ST_MERGE_B,
		ST_WALK_START,
		ST_WALK_UP,
		ST_WALK_CMP,
		ST_EMIT
	} state_t;

	state_t state_q, state_nxt;

	// Decode commands and next state
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: begin
				cmd.accept_en = 1'b1;
				if (sts.in_last_fire) state_nxt = ST_INIT;
			end
			ST_INIT: begin
				cmd.build_init = 1'b1;
				state_nxt = sts.single ? ST_WALK_START : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_MERGE_A;
			end
			ST_MERGE_A: begin
				cmd.merge_a = 1'b1;
				state_nxt = ST_MERGE_B;
			end
			ST_MERGE_B: begin
				cmd.merge_b = 1'b1;
				state_nxt = sts.merge_done ? ST_WALK_START : ST_SCAN;
			end
			ST_WALK_START: begin
				cmd.walk_init = 1'b1;
				state_nxt = ST_WALK_UP;
			end
			ST_WALK_UP: begin
				cmd.walk_fetch = 1'b1;
				state_nxt = sts.has_parent ? ST_WALK_CMP : ST_EMIT;
			end
			ST_WALK_CMP: begin
				cmd.walk_step = 1'b1;
				if (!sts.has_parent) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nxt = sts.last_leaf ? ST_LOAD : ST_WALK_START;
				end
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== hw/rtl/huffman_tree_code_builder.sv =====
// Weights: one beat per cycle while loading; the last weight starts the build.
// Build: for n symbols, a setup state, then each merge at node i is a serial scan of
// the weight store followed by a read drain and two parent writes.
// Codes: each walks up the parent store, one walk step per cycle, then waits to emit until the output beat is free.
// Reset clears all control state and the output beat; node stores are not cleared.
module huffman_tree_code_builder (
	input  logic       clk,
	input  logic       arst_n,
	htcb_in_if.sink    weights,
	htcb_out_if.source codes
);
	import htcb_pkg::*;

	htcb_cmd_t cmd;
	htcb_sts_t sts;

	htcb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	htcb_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.weights (weights),
		.codes   (codes)
	);

endmodule

// ===== hw/rtl/htcb_checker.sv =====
`include "huffman_tree_code_builder_macros.svh"

module htcb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        weights_valid,
	input logic                        weights_ready,
	input logic                        weights_last_weight,
	input logic                        codes_valid,
	input logic                        codes_ready,
	input logic [htcb_pkg::SYM_W-1:0]  codes_symbol,
	input logic [htcb_pkg::CODE_W-1:0] codes_code_bits,
	input logic [htcb_pkg::CLEN_W-1:0] codes_code_length,
	input logic                        codes_last_code
);
	import htcb_pkg::*;

	// Hold a stalled code beat
	`HTCB_ASSERT_NEXT(a_code_hold, clk, arst_n, codes_valid && !codes_ready, codes_valid)
	// Drop ready once the final weight is taken
	`HTCB_ASSERT_NEXT(a_build_busy, clk, arst_n, weights_valid && weights_ready && weights_last_weight, !weights_ready)
	// Zero length only for a lone symbol
	`HTCB_ASSERT_IMPL(a_len_zero, clk, arst_n, codes_valid && codes_code_length == '0, codes_last_code && codes_symbol == '0)
	// No code bits above the length
	`HTCB_ASSERT_IMPL(a_bits_fit, clk, arst_n, codes_valid, (codes_code_bits >> codes_code_length) == '0)

endmodule

bind huffman_tree_code_builder htcb_checker u_htcb_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.weights_valid       (weights.valid),
	.weights_ready       (weights.ready),
	.weights_last_weight (weights.last_weight),
	.codes_valid         (codes.valid),
	.codes_ready         (codes.ready),
	.codes_symbol        (codes.symbol),
	.codes_code_bits     (codes.code_bits),
	.codes_code_length   (codes.code_length),
	.codes_last_code     (codes.last_code)
);

// ===== test/htcb_code_checker.sv =====
module htcb_code_checker (
	input  logic clk,
	input  logic arst_n,
	htcb_in_if   weights,
	htcb_out_if  codes,
	output int   mismatches,
	output int   codes_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import htcb_pkg::*;

	typedef struct packed {
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_bits;
		logic [CLEN_W-1:0] code_length;
		logic              last_code;
	} code_beat_t;

	// Predicted tree: leaves first, merged nodes after them
	logic [NODE_W-1:0] tree_weight [NODE_COUNT];
	int                tree_parent [NODE_COUNT];
	int                tree_left   [NODE_COUNT];
	int                leaves_held;
	code_beat_t        code_queue [$];

	// Lightest node below limit with no parent, skipping one; ties go to the lower index
	function automatic int lightest_orphan(int limit, int skip);
		int best;
		bit found;
		best = 0;
		found = 1'b0;
		for (int j = 0; j < limit; j++) begin
			if (tree_parent[j] != 0 || j == skip)
				continue;
			if (!found || tree_weight[j] < tree_weight[best]) begin
				best = j;
				found = 1'b1;
			end
		end
		return best;
	endfunction

	// Store one weight; on the final one build the tree and queue every code
	function automatic void take_weight(logic [IN_W-1:0] w, logic fin);
		int n;
		int s1;
		int s2;
		int child;
		int up;
		int depth;
		logic [63:0] path;
		code_beat_t beat;
		if (leaves_held < MAX_SYMBOLS) begin
			tree_weight[leaves_held] = NODE_W'(w) & WMASK;
			tree_parent[leaves_held] = 0;
			leaves_held++;
		end
		if (!fin)
			return;
		n = leaves_held;
		for (int i = 0; i < 2 * n - 1; i++)
			tree_parent[i] = 0;
		// Join the two lightest orphans; the lightest goes right
		for (int i = n; i < 2 * n - 1; i++) begin
			s1 = lightest_orphan(i, NODE_COUNT);
			s2 = lightest_orphan(i, s1);
			tree_parent[s1] = i;
			tree_parent[s2] = i;
			tree_weight[i] = tree_weight[s1] + tree_weight[s2];
			tree_left[i] = s2;
		end
		// Walk each leaf to the root, filling code bits from the low end
		for (int i = 0; i < n; i++) begin
			path = '0;
			depth = 0;
			child = i;
			up = tree_parent[i];
			while (up != 0 && up < NODE_COUNT && depth < 63) begin
				if (tree_left[up] != child)
					path[depth] = 1'b1;
				depth++;
				child = up;
				up = tree_parent[up];
			end
			beat.symbol      = SYM_W'(i);
			beat.code_bits   = path[CODE_W-1:0];
			beat.code_length = CLEN_W'(depth);
			beat.last_code   = (i == n - 1);
			code_queue.push_back(beat);
		end
		leaves_held = 0;
	endfunction

	function automatic void check_field(string name, logic [CODE_W-1:0] want,
		logic [CODE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Follow both channels; compare each code beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		code_beat_t want;
		if (!arst_n) begin
			leaves_held = 0;
			for (int i = 0; i < NODE_COUNT; i++)
				tree_parent[i] = 0;
			code_queue.delete();
			mismatches = 0;
			codes_pending = 0;
		end else begin
			if (codes.valid && codes.ready) begin
				if (code_queue.size() == 0) begin
					$error("code beat for symbol %0d with no code expected", codes.symbol);
					mismatches++;
				end else begin
					want = code_queue.pop_front();
					check_field("symbol", CODE_W'(want.symbol), CODE_W'(codes.symbol));
					check_field("code_bits", want.code_bits, codes.code_bits);
					check_field("code_length", CODE_W'(want.code_length),
						CODE_W'(codes.code_length));
					check_field("last_code", CODE_W'(want.last_code),
						CODE_W'(codes.last_code));
				end
			end
			if (weights.valid && weights.ready)
				take_weight(weights.weight, weights.last_weight);
			codes_pending = code_queue.size();
		end
	end

endmodule

// ===== test/huffman_tree_code_builder_test.sv =====
module huffman_tree_code_builder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import htcb_pkg::*;

	localparam int RANDOM_ITEMS    = 255;
	localparam int CALM_TAIL       = 40;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STALL_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 40;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   codes_pending;
	bit   calm = 1'b0;
	bit   hold_off_wanted = 1'b0;
	bit   held_off = 1'b0;

	htcb_in_if  weights ();
	htcb_out_if codes ();

	always #2 clk = ~clk;

	huffman_tree_code_builder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.weights(weights),
		.codes  (codes)
	);

	htcb_code_checker code_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.weights      (weights),
		.codes        (codes),
		.mismatches   (mismatches),
		.codes_pending(codes_pending)
	);

	// Offer one weight beat, sometimes after a short gap, and hold it until taken
	task automatic send_weight(input logic [IN_W-1:0] w, input logic fin);
		if (!calm && $urandom_range(0, 4) == 0) begin
			weights.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		weights.valid       <= 1'b1;
		weights.weight      <= w;
		weights.last_weight <= fin;
		@(posedge clk);
		while (!weights.ready)
			@(posedge clk);
	endtask

	function automatic logic [IN_W-1:0] pick_weight(int style);
		case (style)
			0: begin
				return IN_W'($urandom_range(0, 7));
			end
			1: begin
				return IN_W'($urandom);
			end
			default: begin
				return IN_W'($urandom >> $urandom_range(16, 31));
			end
		endcase
	endfunction

	// Lone symbol, weight extremes, ties, deepest tree and capacity overflow
	task automatic run_directed();
		logic [IN_W-1:0] fib_a;
		logic [IN_W-1:0] fib_b;
		logic [IN_W-1:0] fib_t;
		fib_a = IN_W'(1);
		fib_b = IN_W'(1);
		send_weight(16'h0000, 1'b1);
		send_weight(16'hFFFF, 1'b0);
		send_weight(16'h0000, 1'b1);
		repeat (3) send_weight(16'd7, 1'b0);
		send_weight(16'd7, 1'b1);
		// Fibonacci weights give the longest codes; two more beats overflow the store
		for (int k = 0; k < MAX_SYMBOLS; k++) begin
			send_weight(fib_a, 1'b0);
			fib_t = fib_a + fib_b;
			fib_a = fib_b;
			fib_b = fib_t;
		end
		send_weight(16'hFFFF, 1'b0);
		send_weight(16'h5A5A, 1'b1);
	endtask

	// Random sets: some lone symbols, mostly small, some larger up to full, a few beyond capacity
	task automatic run_random();
		int sent;
		int set_size;
		int style;
		int pick;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				set_size = 1;
			else if (pick <= 6)
				set_size = $urandom_range(2, 6);
			else if (pick <= 8)
				set_size = $urandom_range(7, MAX_SYMBOLS);
			else
				set_size = $urandom_range(MAX_SYMBOLS + 1, MAX_SYMBOLS + 4);
			style = $urandom_range(0, 2);
			for (int k = 0; k < set_size; k++)
				send_weight(pick_weight(style), k == set_size - 1);
			sent += set_size;
			if (sent >= RANDOM_ITEMS - CALM_TAIL)
				calm = 1'b1;
		end
	endtask

	// Drive stimulus, then wait for every code and give the verdict
	initial begin
		arst_n              <= 1'b0;
		weights.valid       <= 1'b0;
		weights.weight      <= '0;
		weights.last_weight <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		hold_off_wanted = 1'b1;
		run_random();
		weights.valid <= 1'b0;
		@(posedge clk);
		while (codes_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && codes_pending == 0) begin
			$display("huffman_tree_code_builder_test: PASS");
		end else begin
			$display("huffman_tree_code_builder_test: FAIL");
		end
		$finish;
	end

	// Code sink: short random stalls, one long hold-off, none at the tail
	initial begin
		codes.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_wanted && !held_off) begin
				held_off = 1'b1;
				codes.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				codes.ready <= 1'b0;
				repeat ($urandom_range(0, 2)) @(posedge clk);
			end else begin
				codes.ready <= 1'b1;
			end
		end
	end

	// Stop the run when no beat moves on either channel for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((weights.valid && weights.ready) || (codes.valid && codes.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("huffman_tree_code_builder_test: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/htcb_pkg.sv
hw/rtl/htcb_in_if.sv
hw/rtl/htcb_out_if.sv
hw/rtl/htcb_datapath.sv
hw/rtl/htcb_ctrl.sv
hw/rtl/huffman_tree_code_builder.sv
hw/rtl/htcb_checker.sv
test/htcb_code_checker.sv
test/huffman_tree_code_builder_test.sv
